>>> src/assert_macros.svh
// assertion helpers shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// next-cycle implication
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

>>> src/bcm_pkg.sv
// ----------------------------------------------------------------------------
// bcm_pkg
// types, codes and constants of the bit cursor memory core
// ----------------------------------------------------------------------------
package bcm_pkg;

    localparam int MEM_BYTES = 65536;
    localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;

    localparam logic [4:0] F_WRBYTE   = 5'd0;
    localparam logic [4:0] F_WRWORD   = 5'd1;
    localparam logic [4:0] F_QBYTE    = 5'd2;
    localparam logic [4:0] F_QWORD    = 5'd3;
    localparam logic [4:0] F_RDBYTE   = 5'd4;
    localparam logic [4:0] F_RDWORD   = 5'd5;
    localparam logic [4:0] F_RDWORDBE = 5'd6;
    localparam logic [4:0] F_SETCUR   = 5'd7;
    localparam logic [4:0] F_RDBITS   = 5'd8;
    localparam logic [4:0] F_ADVANCE  = 5'd9;
    localparam logic [4:0] F_AND      = 5'd10;
    localparam logic [4:0] F_OR       = 5'd11;
    localparam logic [4:0] F_XOR      = 5'd12;
    localparam logic [4:0] F_NOT      = 5'd13;
    localparam logic [4:0] F_INC      = 5'd14;
    localparam logic [4:0] F_DEC      = 5'd15;
    localparam logic [4:0] F_SHR      = 5'd16;
    localparam logic [4:0] F_SHL      = 5'd17;
    localparam logic [4:0] F_TEST     = 5'd18;

    typedef struct packed {
        logic [4:0]  func;
        logic        wide;
        logic        use_position;
        logic [15:0] address;
        logic [2:0]  bit_position;
        logic [4:0]  field_length;
        logic [15:0] operand;
        logic [4:0]  shift_count;
        logic        flow_left;
    } t_in_item;

    typedef struct packed {
        logic [15:0] read_data;
        logic [15:0] cursor_index;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_DECODE,
        S_RD_ISSUE,
        S_RD_WAIT,
        S_BIT_ISSUE,
        S_BIT_WAIT,
        S_MODIFY,
        S_WR,
        S_DONE
    } t_state;

    // command from controller to datapath
    typedef struct packed {
        logic load;      // latch the accepted item, apply use_position
        logic clr_wr;    // write zero at clear pointer, advance it
        logic rd_req;    // read byte at access pointer or cursor
        logic rd_take;   // capture read byte into data word
        logic bit_take;  // take one bit from the cursor byte
        logic modify;    // compute rmw value
        logic wr_req;    // write byte at access pointer
        logic finish;    // form the result
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic clr_last;
        logic need_rd;   // more bytes to read
        logic need_wr;   // more bytes to write
        logic is_bits;
        logic bits_left;
        logic is_rmw;
        logic is_write;
    } t_sts;

endpackage

>>> src/bcm_ctrl.sv
// ----------------------------------------------------------------------------
// bcm_ctrl
// sequencer for the bit cursor memory core
// ----------------------------------------------------------------------------
module bcm_ctrl
    import bcm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy,
    output logic o_strobe
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:     if (i_sts.clr_last) n_state = S_IDLE;
            S_IDLE:      if (i_start) n_state = S_DECODE;
            S_DECODE: begin
                priority if (i_sts.is_bits) n_state = i_sts.bits_left ? S_BIT_ISSUE : S_DONE;
                else if (i_sts.need_rd) n_state = S_RD_ISSUE;
                else if (i_sts.is_write) n_state = S_WR;
                else n_state = S_DONE;
            end
            S_RD_ISSUE:  n_state = S_RD_WAIT;
            S_RD_WAIT: begin
                priority if (i_sts.need_rd) n_state = S_RD_ISSUE;
                else if (i_sts.is_rmw) n_state = S_MODIFY;
                else n_state = S_DONE;
            end
            S_BIT_ISSUE: n_state = S_BIT_WAIT;
            S_BIT_WAIT:  n_state = i_sts.bits_left ? S_BIT_ISSUE : S_DONE;
            S_MODIFY:    n_state = i_sts.need_wr ? S_WR : S_DONE;
            S_WR:        n_state = i_sts.need_wr ? S_WR : S_DONE;
            S_DONE:      n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd    = '0;
        o_busy   = 1'b1;
        o_strobe = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                o_cmd.load = i_start;
            end
            S_CLEAR:     o_cmd.clr_wr = 1'b1;
            S_RD_ISSUE:  o_cmd.rd_req = 1'b1;
            S_RD_WAIT:   o_cmd.rd_take = 1'b1;
            S_BIT_ISSUE: o_cmd.rd_req = 1'b1;
            S_BIT_WAIT:  o_cmd.bit_take = 1'b1;
            S_MODIFY:    o_cmd.modify = 1'b1;
            // entered only with a byte left to write
            S_WR:        o_cmd.wr_req = 1'b1;
            S_DONE: begin
                o_cmd.finish = 1'b1;
                o_strobe = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

>>> src/bcm_dp.sv
// ----------------------------------------------------------------------------
// bcm_dp
// byte store, cursor and operand datapath
// ----------------------------------------------------------------------------
module bcm_dp
    import bcm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    output t_out_item o_result
);

    logic [7:0] r_mem [MEM_BYTES];
    logic [7:0] r_rdata;

    t_in_item    r_item;
    logic [AW-1:0] r_cur_byte, n_cur_byte;
    logic [2:0]  r_cur_bit;
    logic        r_flow;
    logic [AW-1:0] r_clr_ptr;
    logic [AW-1:0] r_ptr;        // access pointer
    logic [1:0]  r_nrd;          // bytes still to read
    logic [1:0]  r_nwr;          // bytes still to write
    logic [4:0]  r_nbits;
    logic [4:0]  r_bit_i;
    logic [15:0] r_data;         // gathered bytes, little-endian
    logic [15:0] r_wval;         // value being written, shifted per byte
    logic [15:0] r_rd;
    logic        r_cursor_rd;    // reads come from the cursor
    logic        r_byte_idx;
    logic [15:0] r_mod_hold;     // rmw value kept for the result

    logic [4:0]  w_func;
    logic        w_cursor_rd;
    logic [1:0]  w_nrd;
    logic [1:0]  w_nwr;
    logic [4:0]  w_flen;
    logic [AW-1:0] w_addr;
    logic [15:0] w_cur;
    logic [15:0] w_opnd;
    logic [15:0] w_mod;
    logic [4:0]  w_wbits;
    logic        w_bit;

    function automatic logic [15:0] r_wval_mod_keep(input logic wide, input logic [15:0] v);
        r_wval_mod_keep = wide ? v : {8'h00, v[7:0]};
    endfunction

    assign w_func = i_item.func;
    assign w_addr = i_item.address[AW-1:0];
    assign w_flen = (i_item.field_length > 5'd16) ? 5'd16 : i_item.field_length;
    assign w_cursor_rd = (w_func == F_RDBYTE) || (w_func == F_RDWORD)
                      || (w_func == F_RDWORDBE);

    always_comb begin
        w_nrd = 2'd0;
        w_nwr = 2'd0;
        unique case (w_func)
            F_WRBYTE:  w_nwr = 2'd1;
            F_WRWORD:  w_nwr = 2'd2;
            F_QBYTE, F_RDBYTE: w_nrd = 2'd1;
            F_QWORD, F_RDWORD, F_RDWORDBE: w_nrd = 2'd2;
            F_AND, F_OR, F_XOR, F_NOT, F_INC, F_DEC, F_SHR, F_SHL: begin
                w_nrd = i_item.wide ? 2'd2 : 2'd1;
                w_nwr = w_nrd;
            end
            F_TEST: w_nrd = i_item.wide ? 2'd2 : 2'd1;
            default: ;
        endcase
    end

    // rmw arithmetic on the gathered value
    assign w_cur   = r_item.wide ? r_data : {8'h00, r_data[7:0]};
    assign w_opnd  = r_item.wide ? r_item.operand : {8'h00, r_item.operand[7:0]};
    assign w_wbits = r_item.wide ? 5'd16 : 5'd8;
    always_comb begin
        unique case (r_item.func)
            F_AND:   w_mod = w_cur & w_opnd;
            F_OR:    w_mod = w_cur | w_opnd;
            F_XOR:   w_mod = w_cur ^ w_opnd;
            F_NOT:   w_mod = ~w_cur;
            F_INC:   w_mod = w_cur + 16'd1;
            F_DEC:   w_mod = w_cur - 16'd1;
            F_SHR:   w_mod = (r_item.shift_count >= w_wbits) ? 16'd0
                            : (w_cur >> r_item.shift_count);
            F_SHL:   w_mod = (r_item.shift_count >= w_wbits) ? 16'd0
                            : (w_cur << r_item.shift_count);
            default: w_mod = 16'd0;
        endcase
        if (!r_item.wide) w_mod[15:8] = 8'h00;
    end

    assign w_bit = r_rdata[r_cur_bit];

    // memory port: one access a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_mem[r_clr_ptr] <= 8'h00;
        end else if (i_cmd.wr_req) begin
            r_mem[r_ptr] <= r_wval[7:0];
        end
        if (i_cmd.rd_req) begin
            r_rdata <= r_mem[r_cursor_rd || r_item.func == F_RDBITS ? r_cur_byte : r_ptr];
        end
    end

    always_comb begin
        n_cur_byte = r_cur_byte;
        if (i_cmd.load) begin
            if ((w_cursor_rd || w_func == F_RDBITS) && i_item.use_position)
                n_cur_byte = w_addr;
            if (w_func == F_SETCUR) n_cur_byte = w_addr;
            if (w_func == F_ADVANCE) n_cur_byte = r_cur_byte + 1'b1;
        end else if (i_cmd.rd_take && r_cursor_rd) begin
            n_cur_byte = r_cur_byte + 1'b1;
        end else if (i_cmd.bit_take) begin
            if (r_flow ? (r_cur_bit == 3'd0) : (r_cur_bit == 3'd7))
                n_cur_byte = r_cur_byte + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_byte <= '0;
            r_cur_bit  <= 3'd0;
            r_flow     <= 1'b0;
            r_clr_ptr  <= '0;
            r_nrd      <= 2'd0;
            r_nwr      <= 2'd0;
            r_nbits    <= 5'd0;
        end else begin
            r_cur_byte <= n_cur_byte;
            if (i_cmd.clr_wr) r_clr_ptr <= r_clr_ptr + 1'b1;
            if (i_cmd.load) begin
                r_nrd   <= w_nrd;
                r_nwr   <= w_nwr;
                r_nbits <= (w_func == F_RDBITS) ? w_flen : 5'd0;
                if (w_func == F_SETCUR) begin
                    r_flow    <= i_item.flow_left;
                    r_cur_bit <= i_item.flow_left ? 3'd7 : 3'd0;
                end
                if (w_func == F_RDBITS && i_item.use_position)
                    r_cur_bit <= i_item.bit_position;
            end
            if (i_cmd.rd_take) r_nrd <= r_nrd - 2'd1;
            if (i_cmd.wr_req)  r_nwr <= r_nwr - 2'd1;
            if (i_cmd.bit_take) begin
                r_nbits <= r_nbits - 5'd1;
                if (r_flow) r_cur_bit <= r_cur_bit - 3'd1;
                else        r_cur_bit <= r_cur_bit + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item      <= i_item;
            r_ptr       <= w_addr;
            r_cursor_rd <= w_cursor_rd;
            r_byte_idx  <= 1'b0;
            r_data      <= 16'd0;
            r_wval      <= i_item.operand;
            r_bit_i     <= 5'd0;
            r_rd        <= 16'd0;
        end
        if (i_cmd.rd_take) begin
            if (r_byte_idx) r_data[15:8] <= r_rdata;
            else            r_data[7:0]  <= r_rdata;
            r_byte_idx <= 1'b1;
            if (!r_cursor_rd) r_ptr <= r_ptr + 1'b1;
        end
        if (i_cmd.bit_take) begin
            if (r_flow) r_rd <= {r_rd[14:0], w_bit};
            else        r_rd <= r_rd | (16'(w_bit) << r_bit_i);
            r_bit_i <= r_bit_i + 5'd1;
        end
        if (i_cmd.modify) begin
            r_wval <= w_mod;
            r_ptr  <= r_item.address[AW-1:0];
        end
        if (i_cmd.wr_req) begin
            r_wval <= {8'h00, r_wval[15:8]};
            r_ptr  <= r_ptr + 1'b1;
        end
        if (i_cmd.finish) begin
            unique case (r_item.func)
                F_QBYTE, F_RDBYTE: r_rd <= {8'h00, r_data[7:0]};
                F_QWORD, F_RDWORD: r_rd <= r_data;
                F_RDWORDBE:        r_rd <= {r_data[7:0], r_data[15:8]};
                F_RDBITS:          r_rd <= r_rd;
                F_AND, F_OR, F_XOR, F_NOT, F_INC, F_DEC, F_SHR, F_SHL:
                    r_rd <= r_wval_mod_keep(r_item.wide, r_mod_hold);
                F_TEST:            r_rd <= {15'd0, (w_cur & w_opnd) == w_opnd};
                default:           r_rd <= 16'd0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.modify) r_mod_hold <= w_mod;
    end

    assign o_sts.clr_last  = (r_clr_ptr == AW'(MEM_BYTES - 1));
    assign o_sts.need_rd   = i_cmd.load ? (w_nrd != 2'd0)
                           : (i_cmd.rd_take ? (r_nrd > 2'd1) : (r_nrd != 2'd0));
    assign o_sts.need_wr   = i_cmd.wr_req ? (r_nwr > 2'd1) : (r_nwr != 2'd0);
    assign o_sts.is_bits   = (r_item.func == F_RDBITS);
    assign o_sts.bits_left = i_cmd.bit_take ? (r_nbits > 5'd1) : (r_nbits != 5'd0);
    assign o_sts.is_rmw    = (r_item.func >= F_AND) && (r_item.func <= F_SHL);
    assign o_sts.is_write  = (r_item.func == F_WRBYTE) || (r_item.func == F_WRWORD);

    // result follows the finish cycle combinationally from registered data
    always_comb begin
        o_result.cursor_index = 16'(r_cur_byte);
        unique case (r_item.func)
            F_QBYTE, F_RDBYTE: o_result.read_data = {8'h00, r_data[7:0]};
            F_QWORD, F_RDWORD: o_result.read_data = r_data;
            F_RDWORDBE:        o_result.read_data = {r_data[7:0], r_data[15:8]};
            F_AND, F_OR, F_XOR, F_NOT, F_INC, F_DEC, F_SHR, F_SHL:
                o_result.read_data = r_wval_mod_keep(r_item.wide, r_mod_hold);
            F_TEST:            o_result.read_data = {15'd0, (w_cur & w_opnd) == w_opnd};
            default:           o_result.read_data = r_rd;
        endcase
    end

endmodule

>>> src/bit_cursor_memory_rmw_core.sv
// ----------------------------------------------------------------------------
// bit_cursor_memory_rmw_core
// byte store with a bit cursor and byte/word read-modify-write
// ----------------------------------------------------------------------------
// One command is taken when start is high and busy low; its result is valid
// on o_result with o_done, a one-cycle strobe, and cannot be held off. The
// store has a single port doing one byte access per cycle. Each command passes
// the idle, decode and done states, plus an issue and a wait state per byte
// read, a modify state for a read-modify-write, a write state per byte written
// and an issue and a wait state per field bit. After reset a clearing pass
// zeroes the store one byte a cycle, with busy high.
module bit_cursor_memory_rmw_core
    import bcm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_done,
    output t_out_item o_result
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in;

    assign w_in = start & ~busy;

    bcm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_in),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_strobe (o_done)
    );

    bcm_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .o_result (o_result)
    );

endmodule

>>> src/bcm_checker.sv
// ----------------------------------------------------------------------------
// bcm_props
// port-level checks of the bit cursor memory core
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module bcm_props
    import bcm_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input logic      o_done
);

    `CHK_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `CHK_IMPL(a_done_busy, i_clk, i_rst_n, o_done, busy)
    `CHK_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)

endmodule

bind bit_cursor_memory_rmw_core bcm_props u_bcm_props (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done)
);
